[rtl/arocs_pkg.sv]
`default_nettype none
package arocs_pkg;

	localparam int ANGLE_W         = 32;
	localparam int MAX_RANGES_DEF  = 64;
	localparam logic [ANGLE_W-1:0] ANGLE_TOP = '1;

	localparam logic [1:0] FUNC_CLEAR = 2'd0;
	localparam logic [1:0] FUNC_ADD   = 2'd1;
	localparam logic [1:0] FUNC_CHECK = 2'd2;

	typedef logic [ANGLE_W-1:0] angle_t;

	// One stored interval, inclusive on both ends.
	typedef struct packed {
		angle_t st;
		angle_t en;
	} ival_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_REMOVE,
		OP_UPDATE
	} cell_op_t;

	// Broadcast control from the sequencer to every cell.
	typedef struct packed {
		cell_op_t op;
		logic     ovl_any;
		logic     ins_ok;
	} cell_ctl_t;

	// Priority chain passed from each cell to the next one up.
	typedef struct packed {
		logic cont;
		logic ovl;
		logic ins;
		logic merge;
	} link_t;

endpackage
`default_nettype wire

[rtl/arocs_cell.sv]
`default_nettype none
module arocs_cell
	import arocs_pkg::*;
(
	input  wire        clk,
	input  cell_ctl_t  ctl,
	input  angle_t     part_s,
	input  angle_t     part_e,
	input  wire        v,
	input  wire        nxt_v,
	input  ival_t      prv,
	input  ival_t      nxt,
	input  link_t      lnk_i,
	output link_t      lnk_o,
	output ival_t      cur,
	output logic       cov_hit
);

	ival_t cur_q;
	logic  cont, scond, econd, ovl, insp, first_ovl, merge_here;

	assign cur = cur_q;

	always_comb begin
		cov_hit    = v && (cur_q.st <= part_s) && (cur_q.en >= part_e);
		cont       = v && (part_s <= cur_q.st) && (part_e >= cur_q.en);
		scond      = v && (part_s < cur_q.st) && (part_e >= cur_q.st);
		econd      = v && (part_s <= cur_q.en) && (part_e > cur_q.en);
		ovl        = scond || econd;
		insp       = !v || (part_e <= cur_q.st);
		first_ovl  = ovl && !lnk_i.ovl;
		merge_here = first_ovl && !scond && nxt_v && (part_e >= nxt.st);
		lnk_o.cont  = lnk_i.cont || cont;
		lnk_o.ovl   = lnk_i.ovl || ovl;
		lnk_o.ins   = lnk_i.ins || insp;
		lnk_o.merge = lnk_i.merge || merge_here;
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_REMOVE: begin
				if (lnk_i.cont || cont) cur_q <= nxt;
			end
			OP_UPDATE: begin
				if (ctl.ovl_any) begin
					if (first_ovl) begin
						if (scond) cur_q.st <= part_s;
						else if (merge_here) cur_q.en <= nxt.en;
						else cur_q.en <= part_e;
					end else if (lnk_i.merge) begin
						cur_q <= nxt;
					end
				end else if (ctl.ins_ok) begin
					if (lnk_i.ins) cur_q <= prv;
					else if (insp) cur_q <= '{st: part_s, en: part_e};
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

[rtl/angle_range_occlusion_set_unit.sv]
`default_nettype none
// Occlusion set of angle intervals, kept sorted and disjoint in a row of cells.
// Command channel: an item (func, start_angle, end_angle) is taken on a rising
// edge where start is high and busy is low. Each item yields one result beat:
// done is high for exactly one cycle while visible, full_res and overflow hold
// the result, and the receiver cannot hold that beat off.
// Steps, from the accepting edge to the result beat:
//   clear and unused codes: straight to the result beat.
//   check: one check pass, and a second for a range that wraps through zero.
//   add: a scan and then an update per part, then the result beat; the scan
//   repeats once for every stored interval that the part swallows, and a part
//   that is already covered skips the update. A wrapping add runs two parts
//   back to back.
// busy stays high until the result beat has gone out, so one item is at work
// at a time and the next item is taken in the cycle after the result beat at
// the earliest. The steps per part come from the cell row: a scan that drops
// a contained interval, and an update that extends, merges or inserts.
// Each cell holds one interval and swaps data with its neighbors, so removal
// shifts the row down and insertion shifts it up by one place per cycle.
// Reset empties the set (the count goes to zero) and returns the sequencer to
// idle; the interval data itself is not cleared, since entries above the count
// are never looked at. An insert into a full row drops the part and raises
// overflow.
module angle_range_occlusion_set_unit
	import arocs_pkg::*;
#(
	parameter int MAX_RANGES = MAX_RANGES_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire  [1:0]         func,
	input  wire  [ANGLE_W-1:0] start_angle,
	input  wire  [ANGLE_W-1:0] end_angle,
	output logic               done,
	output logic               visible,
	output logic               full_res,
	output logic               overflow
);

	localparam int CNT_W = $clog2(MAX_RANGES + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_UPDATE,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	angle_t            part_s_q, part_e_q, e2_q;
	logic              wrap_q, vis_q, ovf_q;

	cell_ctl_t         ctl;
	ival_t             cur     [MAX_RANGES];
	logic              cov_hit [MAX_RANGES];
	logic [MAX_RANGES-1:0] v_vec, cover_vec;
	link_t             lnk     [MAX_RANGES+1];
	logic              cover_any, cont_any, ovl_any, merged, row_full;

	assign lnk[0] = '0;

	for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
		ival_t prv_d, nxt_d;
		logic  nxt_v_d;

		assign v_vec[i]     = IDX < count_q;
		assign cover_vec[i] = cov_hit[i];

		if (i == 0) begin : g_first
			assign prv_d = '0;
		end else begin : g_mid
			assign prv_d = cur[i-1];
		end
		if (i == MAX_RANGES - 1) begin : g_last
			assign nxt_d   = '0;
			assign nxt_v_d = 1'b0;
		end else begin : g_nxt
			assign nxt_d   = cur[i+1];
			assign nxt_v_d = v_vec[i+1];
		end

		arocs_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.part_s  (part_s_q),
			.part_e  (part_e_q),
			.v       (v_vec[i]),
			.nxt_v   (nxt_v_d),
			.prv     (prv_d),
			.nxt     (nxt_d),
			.lnk_i   (lnk[i]),
			.lnk_o   (lnk[i+1]),
			.cur     (cur[i]),
			.cov_hit (cov_hit[i])
		);
	end

	assign cover_any = |cover_vec;
	assign cont_any  = lnk[MAX_RANGES].cont;
	assign ovl_any   = lnk[MAX_RANGES].ovl;
	assign merged    = lnk[MAX_RANGES].merge;
	assign row_full  = v_vec[MAX_RANGES-1];

	// The row only moves in two states: a scan cycle that finds a contained
	// interval drops it, and the update cycle extends, merges or inserts.
	always_comb begin
		ctl.op      = OP_HOLD;
		ctl.ovl_any = ovl_any;
		ctl.ins_ok  = !row_full;
		if (state_q == ST_SCAN && !cover_any && cont_any) ctl.op = OP_REMOVE;
		if (state_q == ST_UPDATE) ctl.op = OP_UPDATE;
	end

	assign busy     = state_q != ST_IDLE;
	assign done     = state_q == ST_DONE;
	assign visible  = vis_q;
	assign overflow = ovf_q;
	assign full_res = (count_q != '0) && (cur[0].st == '0) && (cur[0].en == ANGLE_TOP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			part_s_q <= '0;
			part_e_q <= '0;
			e2_q     <= '0;
			wrap_q   <= 1'b0;
			vis_q    <= 1'b0;
			ovf_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						vis_q    <= 1'b0;
						ovf_q    <= 1'b0;
						e2_q     <= end_angle;
						part_s_q <= start_angle;
						if (start_angle > end_angle) begin
							part_e_q <= ANGLE_TOP;
							wrap_q   <= 1'b1;
						end else begin
							part_e_q <= end_angle;
							wrap_q   <= 1'b0;
						end
						unique case (func)
							FUNC_CLEAR: begin
								count_q <= '0;
								state_q <= ST_DONE;
							end
							FUNC_ADD:   state_q <= ST_SCAN;
							FUNC_CHECK: state_q <= ST_CHECK;
							default:    state_q <= ST_DONE;
						endcase
					end
				end
				ST_CHECK: begin
					if (!cover_any) vis_q <= 1'b1;
					if (wrap_q) begin
						wrap_q   <= 1'b0;
						part_s_q <= '0;
						part_e_q <= e2_q;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_SCAN: begin
					if (cover_any) begin
						if (wrap_q) begin
							wrap_q   <= 1'b0;
							part_s_q <= '0;
							part_e_q <= e2_q;
						end else begin
							state_q <= ST_DONE;
						end
					end else if (cont_any) begin
						count_q <= count_q - 1'b1;
					end else begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (ovl_any) begin
						if (merged) count_q <= count_q - 1'b1;
					end else if (row_full) begin
						ovf_q <= 1'b1;
					end else begin
						count_q <= count_q + 1'b1;
					end
					if (wrap_q) begin
						wrap_q   <= 1'b0;
						part_s_q <= '0;
						part_e_q <= e2_q;
						state_q  <= ST_SCAN;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
